/* hdl/poe_pkg.sv */
// ----------------------------------------------------------------------------
// poe_pkg: shared constants for the pulse oximetry estimator
// Register indexes, reset values, fixed-point constants and default sizes.
// ----------------------------------------------------------------------------
package poe_pkg;

  localparam int RATE_DEPTH_DEF  = 10;
  localparam int SAMPLE_BITS_DEF = 18;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 18;

  localparam logic [CFG_INDEX_W-1:0] CFG_THRESHOLD  = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_WINDOW     = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_LEVEL_F    = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_ESTIMATE_F = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_FLOOR      = 3'd4;

  localparam logic [17:0] THRESHOLD_RST  = 18'd7000;
  localparam logic [7:0]  WINDOW_RST     = 8'd30;
  localparam logic [15:0] LEVEL_F_RST    = 16'd62259;
  localparam logic [15:0] ESTIMATE_F_RST = 16'd45875;
  localparam logic [9:0]  FLOOR_RST      = 10'd900;

  // Beat intervals that give a rate strictly between 20 and 255 bpm.
  localparam logic [15:0] BPM_NUMERATOR = 16'd60000;
  localparam logic [31:0] BEAT_MIN_MS   = 32'd236;
  localparam logic [31:0] BEAT_MAX_MS   = 32'd2999;

  localparam logic [9:0]  SPO2_CEIL = 10'd999;
  // 65536000 + 233 * 26214: the linear map folded into one offset.
  localparam logic [26:0] SPO2_BASE_Q16 = 27'd71643862;
  localparam logic [7:0]  SPO2_SLOPE    = 8'd233;

  localparam int RATIO_W = 47;
  localparam int RMS_W   = 32;
  localparam int SQ_W    = 64;

endpackage

/* hdl/poe_mul.sv */
// ----------------------------------------------------------------------------
// poe_mul: bit-serial unsigned multiplier
// One multiplier bit per cycle, shift-and-add into a product register.
// ----------------------------------------------------------------------------
module poe_mul import poe_pkg::*; #(
  parameter int A_W = 49,
  parameter int B_W = 26
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [A_W-1:0]     a,
  input  logic [B_W-1:0]     b,
  output logic               done,
  output logic [A_W+B_W-1:0] product
);

  localparam int CNT_W = $clog2(B_W + 1);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [A_W-1:0]   a_hold;
  logic [A_W:0]     sum;

  assign sum = {1'b0, product[A_W+B_W-1:B_W]} + (product[0] ? {1'b0, a_hold} : '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(B_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_hold  <= a;
      product <= {{A_W{1'b0}}, b};
    end else if (busy) begin
      product <= {sum, product[B_W-1:1]};
    end
  end

endmodule

/* hdl/poe_div.sv */
// ----------------------------------------------------------------------------
// poe_div: bit-serial restoring divider
// One quotient bit per cycle. A zero divisor gives an all-ones quotient.
// ----------------------------------------------------------------------------
module poe_div import poe_pkg::*; #(
  parameter int N_W = 63,
  parameter int D_W = 47
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  logic [N_W-1:0] num,
  input  logic [D_W-1:0] den,
  output logic           done,
  output logic [N_W-1:0] quotient
);

  localparam int CNT_W = $clog2(N_W + 1);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [D_W-1:0]   den_hold;
  logic [D_W-1:0]   rem;
  logic [D_W:0]     trial;
  logic [D_W:0]     diff;
  logic             fits;

  assign trial = {rem, quotient[N_W-1]};
  assign diff  = trial - {1'b0, den_hold};
  assign fits  = trial >= {1'b0, den_hold};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(N_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      den_hold <= den;
      rem      <= '0;
      quotient <= num;
    end else if (busy) begin
      rem      <= fits ? diff[D_W-1:0] : trial[D_W-1:0];
      quotient <= {quotient[N_W-2:0], fits};
    end
  end

endmodule

/* hdl/poe_sqrt.sv */
// ----------------------------------------------------------------------------
// poe_sqrt: digit-serial integer square root
// Two radicand bits per cycle, one root bit per cycle, floor result.
// ----------------------------------------------------------------------------
module poe_sqrt import poe_pkg::*; #(
  parameter int W = 64
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  logic [W-1:0]   radicand,
  output logic           done,
  output logic [W/2-1:0] root
);

  localparam int H     = W / 2;
  localparam int CNT_W = $clog2(H + 1);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [W-1:0]     v;
  logic [H:0]       rem;
  logic [H+2:0]     rem2;
  logic [H+2:0]     trial;
  logic             fits;

  assign rem2  = {rem, v[W-1:W-2]};
  assign trial = {1'b0, root, 2'b01};
  assign fits  = rem2 >= trial;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(H - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      v    <= radicand;
      rem  <= '0;
      root <= '0;
    end else if (busy) begin
      v    <= {v[W-3:0], 2'b00};
      rem  <= fits ? (H+1)'(rem2 - trial) : rem2[H:0];
      root <= {root[H-2:0], fits};
    end
  end

endmodule

/* hdl/pulse_oximetry_estimator_unit.sv */
// ----------------------------------------------------------------------------
// pulse_oximetry_estimator_unit: ratio-of-ratios SpO2 and beat-rate averager
// Sequencer around a shared bit-serial multiplier, divider and square root.
// ----------------------------------------------------------------------------
//
//   channel | direction | handshake              | carries
//   --------+-----------+------------------------+------------------------------
//   in      | to block  | in_valid / in_stall    | presence, beat, time, samples
//   out     | from block| out_valid / out_stall  | finger_detected, beat_average,
//           |           |                        | spo2_tenths, estimate_updated
//   cfg     | to block  | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// One item is worked on at a time; in_stall is low only in the idle state.
// An item without a finger goes straight from idle to the output stage; a
// finger item with neither a valid beat nor a sample passes through the beat
// and sample checks only. A valid beat adds two divider passes over 63
// quotient bits; each sample channel adds three multiplier passes (26
// multiplier bits at 18-bit samples) and a deviation step, and a window
// end adds two square roots, three divisions and four multiplications.
// A result waits in the output register while the next item is taken in.
// Reset (rst, synchronous) restores the register defaults and clears the estimator
// state, with the estimate at its floor; the first item may follow at once.
//
module pulse_oximetry_estimator_unit import poe_pkg::*; #(
  parameter int RATE_DEPTH  = RATE_DEPTH_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [17:0]            presence_level,
  input  logic                   beat_seen,
  input  logic [31:0]            now_ms,
  input  logic                   sample_valid,
  input  logic [17:0]            red_sample,
  input  logic [17:0]            ir_sample,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic                   finger_detected,
  output logic [7:0]             beat_average,
  output logic [9:0]             spo2_tenths,
  output logic                   estimate_updated,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  // Sizes that follow from the sample width and ring depth.
  localparam int SW       = SAMPLE_BITS;
  localparam int XW       = (SW < 18) ? SW : 18;
  localparam int MEAN_W   = SW + 16;
  localparam int D8_W     = MEAN_W - 8;
  localparam int MUL_A_W  = (MEAN_W > 49) ? MEAN_W : 49;
  localparam int MUL_B_W  = (D8_W > 17) ? D8_W : 17;
  localparam int MUL_P_W  = MUL_A_W + MUL_B_W;
  localparam int DIV_N_W  = 63;
  localparam int DIV_D_W  = (MEAN_W > RATIO_W) ? MEAN_W : RATIO_W;
  localparam int SLOT_W   = (RATE_DEPTH > 1) ? $clog2(RATE_DEPTH) : 1;
  localparam int SUM_W    = $clog2(RATE_DEPTH * 255 + 1);

  // Sequencer states.
  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_BEAT  = 5'd1;
  localparam logic [4:0] S_BPM   = 5'd2;
  localparam logic [4:0] S_AVG   = 5'd3;
  localparam logic [4:0] S_SAMP  = 5'd4;
  localparam logic [4:0] S_MF    = 5'd5;
  localparam logic [4:0] S_XG    = 5'd6;
  localparam logic [4:0] S_DEV   = 5'd7;
  localparam logic [4:0] S_SQ    = 5'd8;
  localparam logic [4:0] S_WIN   = 5'd9;
  localparam logic [4:0] S_SQRT  = 5'd10;
  localparam logic [4:0] S_RATIO = 5'd11;
  localparam logic [4:0] S_RDIV  = 5'd12;
  localparam logic [4:0] S_MT    = 5'd13;
  localparam logic [4:0] S_MU    = 5'd14;
  localparam logic [4:0] S_MP    = 5'd15;
  localparam logic [4:0] S_MG    = 5'd16;
  localparam logic [4:0] S_EST   = 5'd17;
  localparam logic [4:0] S_FIN   = 5'd18;

  logic [4:0] state;

  // Configuration registers.
  logic [17:0] finger_threshold;
  logic [7:0]  samples_per_estimate;
  logic [15:0] level_filter_factor;
  logic [15:0] estimate_filter_factor;
  logic [9:0]  spo2_floor_tenths;

  // Estimator state.
  logic [7:0]        rate_ring [RATE_DEPTH];
  logic [SLOT_W-1:0] rate_slot;
  logic [SUM_W-1:0]  rate_sum;
  logic [31:0]       last_beat_time;
  logic [7:0]        average_bpm;
  logic [MEAN_W-1:0] mean [2];
  logic [SQ_W-1:0]   square_sum [2];
  logic [7:0]        window_count;
  logic [9:0]        spo2_estimate;

  // Item in progress.
  logic          item_beat;
  logic [31:0]   item_now;
  logic          item_sample;
  logic [SW-1:0] item_x [2];
  logic          item_finger;
  logic          item_updated;
  logic          ch;

  // Working registers.
  logic [MUL_P_W-1:0] p_hold;
  logic [56:0]        u_hold;
  logic [45:0]        acc_pos;
  logic [RATIO_W-1:0] ratio [2];

  // Shared arithmetic units.
  logic               mul_go, div_go, sqrt_go;
  logic [MUL_A_W-1:0] mul_a;
  logic [MUL_B_W-1:0] mul_b;
  logic               mul_done;
  logic [MUL_P_W-1:0] mul_prod;
  logic [DIV_N_W-1:0] div_num;
  logic [DIV_D_W-1:0] div_den;
  logic               div_done;
  logic [DIV_N_W-1:0] div_q;
  logic               sqrt_done;
  logic [RMS_W-1:0]   sqrt_root;

  poe_mul #(.A_W(MUL_A_W), .B_W(MUL_B_W)) u_mul (
    .clk(clk), .rst(rst), .start(mul_go), .a(mul_a), .b(mul_b),
    .done(mul_done), .product(mul_prod)
  );

  poe_div #(.N_W(DIV_N_W), .D_W(DIV_D_W)) u_div (
    .clk(clk), .rst(rst), .start(div_go), .num(div_num), .den(div_den),
    .done(div_done), .quotient(div_q)
  );

  poe_sqrt #(.W(SQ_W)) u_sqrt (
    .clk(clk), .rst(rst), .start(sqrt_go), .radicand(square_sum[ch]),
    .done(sqrt_done), .root(sqrt_root)
  );

  // Combinational helpers.
  logic              in_take;
  logic              out_free;
  logic [31:0]       delta;
  logic [SUM_W-1:0]  sum_next;
  logic [16:0]       level_keep_rest;
  logic [16:0]       est_keep_rest;
  logic [MEAN_W-1:0] xs;
  logic [MEAN_W+17:0] mean_sum;
  logic [MEAN_W-1:0] dev;
  logic [MEAN_W-1:0] dev_round;
  logic [SQ_W:0]     sq_add;
  logic [7:0]        count_next;
  logic [45:0]       est_diff;
  logic [46:0]       est_round;
  logic [13:0]       est_raw;
  logic [13:0]       est_low;

  assign in_stall  = (state != S_IDLE);
  assign in_take   = in_valid && !in_stall;
  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid || !out_stall;

  assign delta           = item_now - last_beat_time;
  assign sum_next        = rate_sum - SUM_W'(rate_ring[rate_slot]) + SUM_W'(div_q[7:0]);
  assign level_keep_rest = 17'h10000 - {1'b0, level_filter_factor};
  assign est_keep_rest   = 17'h10000 - {1'b0, estimate_filter_factor};
  assign xs              = {item_x[ch], 16'h0000};
  assign mean_sum        = (MEAN_W+18)'(p_hold[MEAN_W+15:0])
                         + (MEAN_W+18)'(mul_prod[MEAN_W+16:0])
                         + (MEAN_W+18)'(32768);
  assign dev             = (xs >= mean[ch]) ? xs - mean[ch] : mean[ch] - xs;
  assign dev_round       = dev + MEAN_W'(128);
  assign sq_add          = {1'b0, square_sum[ch]} + (SQ_W+1)'(mul_prod[2*D8_W-1:0]);
  assign count_next      = window_count + 8'd1;

  // Final blend: the negative part of the sum is u_hold; a result below zero
  // reads as zero.
  assign est_diff  = acc_pos - u_hold[45:0];
  assign est_round = {1'b0, est_diff} + 47'h0_8000_0000;
  assign est_raw   = ((57'(acc_pos)) < u_hold) ? 14'd0 : est_round[45:32];
  assign est_low   = (est_raw <= 14'(spo2_floor_tenths)) ? 14'(spo2_floor_tenths) : est_raw;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      finger_threshold       <= THRESHOLD_RST;
      samples_per_estimate   <= WINDOW_RST;
      level_filter_factor    <= LEVEL_F_RST;
      estimate_filter_factor <= ESTIMATE_F_RST;
      spo2_floor_tenths      <= FLOOR_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_THRESHOLD:  finger_threshold       <= cfg_data[17:0];
        CFG_WINDOW:     samples_per_estimate   <= cfg_data[7:0];
        CFG_LEVEL_F:    level_filter_factor    <= cfg_data[15:0];
        CFG_ESTIMATE_F: estimate_filter_factor <= cfg_data[15:0];
        CFG_FLOOR:      spo2_floor_tenths      <= cfg_data[9:0];
        default: ;
      endcase
    end
  end

  // Sequencer and estimator state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      mul_go         <= 1'b0;
      div_go         <= 1'b0;
      sqrt_go        <= 1'b0;
      out_valid      <= 1'b0;
      for (int i = 0; i < RATE_DEPTH; i++) rate_ring[i] <= 8'd0;
      rate_slot      <= '0;
      rate_sum       <= '0;
      last_beat_time <= 32'd0;
      average_bpm    <= 8'd0;
      mean[0]        <= '0;
      mean[1]        <= '0;
      square_sum[0]  <= '0;
      square_sum[1]  <= '0;
      window_count   <= 8'd0;
      spo2_estimate  <= FLOOR_RST;
      ch             <= 1'b0;
    end else begin
      mul_go  <= 1'b0;
      div_go  <= 1'b0;
      sqrt_go <= 1'b0;
      if (out_valid && !out_stall) out_valid <= 1'b0;

      case (state)
        S_IDLE: begin
          if (in_take) begin
            item_beat    <= beat_seen;
            item_now     <= now_ms;
            item_sample  <= sample_valid;
            item_x[0]    <= SW'(red_sample[XW-1:0]);
            item_x[1]    <= SW'(ir_sample[XW-1:0]);
            item_updated <= 1'b0;
            ch           <= 1'b0;
            if (presence_level <= finger_threshold) begin
              // No finger: everything goes back to its starting point.
              item_finger    <= 1'b0;
              for (int i = 0; i < RATE_DEPTH; i++) rate_ring[i] <= 8'd0;
              rate_slot      <= '0;
              rate_sum       <= '0;
              last_beat_time <= 32'd0;
              average_bpm    <= 8'd0;
              mean[0]        <= '0;
              mean[1]        <= '0;
              square_sum[0]  <= '0;
              square_sum[1]  <= '0;
              window_count   <= 8'd0;
              spo2_estimate  <= spo2_floor_tenths;
              state          <= S_FIN;
            end else begin
              item_finger <= 1'b1;
              state       <= S_BEAT;
            end
          end
        end

        S_BEAT: begin
          state <= S_SAMP;
          if (item_beat) begin
            last_beat_time <= item_now;
            if (delta >= BEAT_MIN_MS && delta <= BEAT_MAX_MS) begin
              div_num <= DIV_N_W'(BPM_NUMERATOR);
              div_den <= DIV_D_W'(delta);
              div_go  <= 1'b1;
              state   <= S_BPM;
            end
          end
        end

        S_BPM: begin
          if (div_done) begin
            rate_sum             <= sum_next;
            rate_ring[rate_slot] <= div_q[7:0];
            rate_slot <= (rate_slot == SLOT_W'(RATE_DEPTH - 1)) ? '0 : rate_slot + 1'b1;
            div_num   <= DIV_N_W'(sum_next);
            div_den   <= DIV_D_W'(RATE_DEPTH);
            div_go    <= 1'b1;
            state     <= S_AVG;
          end
        end

        S_AVG: begin
          if (div_done) begin
            average_bpm <= div_q[7:0];
            state       <= S_SAMP;
          end
        end

        S_SAMP: begin
          if (item_sample) begin
            mul_a  <= MUL_A_W'(mean[ch]);
            mul_b  <= MUL_B_W'(level_filter_factor);
            mul_go <= 1'b1;
            state  <= S_MF;
          end else begin
            state <= S_FIN;
          end
        end

        S_MF: begin
          if (mul_done) begin
            p_hold <= mul_prod;
            mul_a  <= MUL_A_W'(xs);
            mul_b  <= MUL_B_W'(level_keep_rest);
            mul_go <= 1'b1;
            state  <= S_XG;
          end
        end

        S_XG: begin
          if (mul_done) begin
            mean[ch] <= mean_sum[MEAN_W+15:16];
            state    <= S_DEV;
          end
        end

        S_DEV: begin
          mul_a  <= MUL_A_W'(dev_round[MEAN_W-1:8]);
          mul_b  <= MUL_B_W'(dev_round[MEAN_W-1:8]);
          mul_go <= 1'b1;
          state  <= S_SQ;
        end

        S_SQ: begin
          if (mul_done) begin
            square_sum[ch] <= sq_add[SQ_W] ? '1 : sq_add[SQ_W-1:0];
            if (!ch) begin
              ch     <= 1'b1;
              mul_a  <= MUL_A_W'(mean[1]);
              mul_b  <= MUL_B_W'(level_filter_factor);
              mul_go <= 1'b1;
              state  <= S_MF;
            end else begin
              state <= S_WIN;
            end
          end
        end

        S_WIN: begin
          if (count_next >= samples_per_estimate) begin
            window_count <= 8'd0;
            ch           <= 1'b0;
            sqrt_go      <= 1'b1;
            state        <= S_SQRT;
          end else begin
            window_count <= count_next;
            state        <= S_FIN;
          end
        end

        S_SQRT: begin
          if (sqrt_done) begin
            div_num <= DIV_N_W'({sqrt_root, 24'h000000});
            div_den <= DIV_D_W'(mean[ch]);
            div_go  <= 1'b1;
            state   <= S_RATIO;
          end
        end

        S_RATIO: begin
          if (div_done) begin
            ratio[ch] <= (div_q > DIV_N_W'({RATIO_W{1'b1}})) ? '1 : div_q[RATIO_W-1:0];
            if (!ch) begin
              ch      <= 1'b1;
              sqrt_go <= 1'b1;
              state   <= S_SQRT;
            end else begin
              // A zero IR ratio divides by zero and saturates in the clamp.
              div_num <= DIV_N_W'({ratio[0], 16'h0000});
              div_den <= DIV_D_W'((div_q > DIV_N_W'({RATIO_W{1'b1}})) ? {RATIO_W{1'b1}}
                                                                      : div_q[RATIO_W-1:0]);
              div_go  <= 1'b1;
              state   <= S_RDIV;
            end
          end
        end

        S_RDIV: begin
          if (div_done) begin
            mul_a  <= MUL_A_W'((div_q > DIV_N_W'(32'hFFFF_FFFF)) ? 32'hFFFF_FFFF : div_q[31:0]);
            mul_b  <= MUL_B_W'(est_keep_rest);
            mul_go <= 1'b1;
            state  <= S_MT;
          end
        end

        S_MT: begin
          if (mul_done) begin
            mul_a  <= MUL_A_W'(mul_prod[48:0]);
            mul_b  <= MUL_B_W'(SPO2_SLOPE);
            mul_go <= 1'b1;
            state  <= S_MU;
          end
        end

        S_MU: begin
          if (mul_done) begin
            u_hold <= mul_prod[56:0];
            mul_a  <= MUL_A_W'(spo2_estimate);
            mul_b  <= MUL_B_W'(estimate_filter_factor);
            mul_go <= 1'b1;
            state  <= S_MP;
          end
        end

        S_MP: begin
          if (mul_done) begin
            p_hold <= mul_prod;
            mul_a  <= MUL_A_W'(SPO2_BASE_Q16);
            mul_b  <= MUL_B_W'(est_keep_rest);
            mul_go <= 1'b1;
            state  <= S_MG;
          end
        end

        S_MG: begin
          if (mul_done) begin
            acc_pos <= {p_hold[29:0], 16'h0000} + mul_prod[45:0];
            state   <= S_EST;
          end
        end

        S_EST: begin
          spo2_estimate <= (est_low > 14'(SPO2_CEIL)) ? SPO2_CEIL : est_low[9:0];
          square_sum[0] <= '0;
          square_sum[1] <= '0;
          item_updated  <= 1'b1;
          state         <= S_FIN;
        end

        S_FIN: begin
          if (out_free) begin
            finger_detected  <= item_finger;
            beat_average     <= average_bpm;
            spo2_tenths      <= spo2_estimate;
            estimate_updated <= item_updated;
            out_valid        <= 1'b1;
            state            <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

/* dv/tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for pulse_oximetry_estimator_unit
// Drives presence/beat/sample transfers under several register settings and
// idling patterns, and checks every result against a cycle-free SpO2 and
// beat-rate predictor kept inside the bench.
// ----------------------------------------------------------------------------
module tb;
  import poe_pkg::*;

  localparam int RING_N      = 10;
  localparam int CYCLE_LIMIT = 3000000;
  localparam int LONG_HOLD   = 2000;

  typedef struct {
    logic [17:0] presence;
    logic        beat;
    logic [31:0] now;
    logic        has_sample;
    logic [17:0] red;
    logic [17:0] ir;
  } reading_t;

  typedef struct {
    logic       finger;
    logic [7:0] bpm_avg;
    logic [9:0] spo2;
    logic       updated;
  } report_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [17:0] presence_level = '0;
  logic        beat_seen = 1'b0;
  logic [31:0] now_ms = '0;
  logic        sample_valid = 1'b0;
  logic [17:0] red_sample = '0;
  logic [17:0] ir_sample = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        finger_detected;
  logic [7:0]  beat_average;
  logic [9:0]  spo2_tenths;
  logic        estimate_updated;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  pulse_oximetry_estimator_unit u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .presence_level(presence_level), .beat_seen(beat_seen), .now_ms(now_ms),
    .sample_valid(sample_valid), .red_sample(red_sample), .ir_sample(ir_sample),
    .out_valid(out_valid), .out_stall(out_stall),
    .finger_detected(finger_detected), .beat_average(beat_average),
    .spo2_tenths(spo2_tenths), .estimate_updated(estimate_updated),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Register copies used by the predictor, updated on each config transfer.
  logic [17:0] thr_reg   = THRESHOLD_RST;
  logic [7:0]  win_reg   = WINDOW_RST;
  logic [15:0] lvl_f_reg = LEVEL_F_RST;
  logic [15:0] est_f_reg = ESTIMATE_F_RST;
  logic [9:0]  floor_reg = FLOOR_RST;

  // Predictor state: beat-rate ring and the two channel filters.
  logic [7:0]  rate_hist [RING_N];
  logic [3:0]  hist_slot;
  logic [11:0] hist_sum;
  logic [31:0] prev_beat_ms;
  logic [7:0]  bpm_mean;
  logic [63:0] red_lvl, ir_lvl, red_var, ir_var;
  logic [7:0]  win_fill;
  logic [9:0]  spo2_est;

  reading_t pending[$];
  report_t  expected_reports[$];
  reading_t drv_item;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int mismatches = 0;
  int cycles = 0;
  logic [31:0] clock_ms = 32'd1000;

  // Long receiver hold-off, requested once by the stimulus sequence.
  logic hold_req = 1'b0;
  logic hold_taken = 1'b0;
  int   hold_left = 0;

  function automatic void clear_track();
    for (int i = 0; i < RING_N; i++) rate_hist[i] = '0;
    hist_slot = '0; hist_sum = '0; prev_beat_ms = '0; bpm_mean = '0;
    red_lvl = '0; ir_lvl = '0; red_var = '0; ir_var = '0; win_fill = '0;
  endfunction

  function automatic logic [63:0] int_sqrt(input logic [63:0] v);
    logic [63:0] r, b;
    r = '0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // One exponential level update plus the squared deviation, Q.8 rounded.
  function automatic void filter_channel(input logic [63:0] x, inout logic [63:0] lvl,
                                         inout logic [63:0] acc);
    logic [63:0] xs, dev, d8, p;
    logic [64:0] total;
    xs = x << 16;
    lvl = (lvl * lvl_f_reg + xs * (64'd65536 - lvl_f_reg) + 64'd32768) >> 16;
    dev = (xs >= lvl) ? xs - lvl : lvl - xs;
    d8 = (dev + 64'd128) >> 8;
    if (d8 > 64'hFFFF_FFFF) d8 = 64'hFFFF_FFFF;
    p = d8 * d8;
    total = {1'b0, acc} + {1'b0, p};
    acc = total[64] ? '1 : total[63:0];
  endfunction

  function automatic logic [63:0] rms_over_mean(input logic [63:0] acc,
                                                input logic [63:0] lvl);
    logic [63:0] q;
    if (lvl == 0) return (64'd1 << 47) - 1;
    q = (int_sqrt(acc) << 24) / lvl;
    return (q > (64'd1 << 47) - 1) ? (64'd1 << 47) - 1 : q;
  endfunction

  function automatic void update_spo2();
    logic [63:0] rr, ri, r, v;
    longint s, fw, acc;
    rr = rms_over_mean(red_var, red_lvl);
    ri = rms_over_mean(ir_var, ir_lvl);
    r = (ri == 0) ? 64'hFFFF_FFFF : (rr << 16) / ri;
    if (r > 64'hFFFF_FFFF) r = 64'hFFFF_FFFF;
    s = 65536000 - 233 * (longint'(r) - 26214);
    fw = longint'(est_f_reg);
    acc = fw * (longint'(spo2_est) * 65536) + (65536 - fw) * s;
    v = (acc < 0) ? 64'd0 : ((64'(acc) + 64'd2147483648) >> 32);
    if (v <= floor_reg) v = floor_reg;
    if (v > SPO2_CEIL) v = SPO2_CEIL;
    spo2_est = v[9:0];
  endfunction

  function automatic report_t predict_report(input reading_t rd);
    report_t rep;
    logic [31:0] delta, bpm;
    rep.updated = 1'b0;
    if (rd.presence <= thr_reg) begin
      clear_track();
      spo2_est = floor_reg;
      rep.finger = 1'b0; rep.bpm_avg = '0; rep.spo2 = spo2_est;
      return rep;
    end
    if (rd.beat) begin
      delta = rd.now - prev_beat_ms;
      prev_beat_ms = rd.now;
      if (delta != 0 && 64'(delta) * 20 < 64'd60000 && 64'(delta) * 255 > 64'd60000) begin
        bpm = 32'd60000 / delta;
        if (hist_slot >= RING_N) hist_slot = '0;
        hist_sum = hist_sum - rate_hist[hist_slot] + bpm[11:0];
        rate_hist[hist_slot] = bpm[7:0];
        hist_slot = 4'((hist_slot + 1) % RING_N);
        bpm_mean = 8'(hist_sum / RING_N);
      end
    end
    if (rd.has_sample) begin
      filter_channel(64'(rd.red), red_lvl, red_var);
      filter_channel(64'(rd.ir), ir_lvl, ir_var);
      win_fill = win_fill + 8'd1;
      if (win_fill >= win_reg) begin
        update_spo2();
        red_var = '0; ir_var = '0; win_fill = '0;
        rep.updated = 1'b1;
      end
    end
    rep.finger = 1'b1; rep.bpm_avg = bpm_mean; rep.spo2 = spo2_est;
    return rep;
  endfunction

  // Input driver: holds a stalled transfer, otherwise offers the next reading
  // unless this cycle is chosen as a sender gap.
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) expected_reports.push_back(predict_report(drv_item));
      if (!(in_valid && in_stall)) begin
        if (pending.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          drv_item = pending.pop_front();
          in_valid       <= 1'b1;
          presence_level <= drv_item.presence;
          beat_seen      <= drv_item.beat;
          now_ms         <= drv_item.now;
          sample_valid   <= drv_item.has_sample;
          red_sample     <= drv_item.red;
          ir_sample      <= drv_item.ir;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Long hold-off counter for the receiver.
  always @(posedge clk) begin
    if (hold_req && !hold_taken) begin
      hold_left  <= LONG_HOLD;
      hold_taken <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Output monitor: compares each result transfer with the oldest expectation.
  always @(posedge clk) begin
    report_t want;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (expected_reports.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result transfer at cycle %0d", cycles);
        end else begin
          want = expected_reports.pop_front();
          if (finger_detected !== want.finger || beat_average !== want.bpm_avg ||
              spo2_tenths !== want.spo2 || estimate_updated !== want.updated) begin
            mismatches++;
            if (mismatches <= 10)
              $display({"mismatch at cycle %0d: expected finger %0d bpm %0d spo2 %0d",
                        " upd %0d, got finger %0d bpm %0d spo2 %0d upd %0d"},
                       cycles, want.finger, want.bpm_avg, want.spo2, want.updated,
                       finger_detected, beat_average, spo2_tenths, estimate_updated);
          end
        end
      end
      out_stall <= (hold_left > 0) || ($urandom_range(0, 99) < recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [31:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val[CFG_DATA_W-1:0];
    forever begin
      @(posedge clk);
      if (cfg_ready) break;
    end
    case (idx)
      CFG_THRESHOLD:  thr_reg   = val[17:0];
      CFG_WINDOW:     win_reg   = val[7:0];
      CFG_LEVEL_F:    lvl_f_reg = val[15:0];
      CFG_ESTIMATE_F: est_f_reg = val[15:0];
      CFG_FLOOR:      floor_reg = val[9:0];
      default: ;
    endcase
    cfg_valid <= 1'b0;
  endtask

  task automatic add_reading(input logic [17:0] p, input logic b, input logic [31:0] t,
                             input logic sv, input logic [17:0] r, input logic [17:0] i);
    reading_t rd;
    rd.presence = p; rd.beat = b; rd.now = t; rd.has_sample = sv; rd.red = r; rd.ir = i;
    pending.push_back(rd);
  endtask

  // Mostly a finger session: rising time, plausible beats, DC plus pulse on
  // both channels. A few absent-finger and fully random readings mixed in.
  task automatic add_session(input int n);
    logic [17:0] pres, red_dc, ir_dc;
    int k;
    red_dc = 18'($urandom_range(1000, 200000));
    ir_dc  = 18'($urandom_range(1000, 200000));
    for (k = 0; k < n; k++) begin
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 4) begin
        add_reading(18'($urandom_range(0, thr_reg)), 1'($urandom_range(0, 1)), $urandom,
                    1'($urandom_range(0, 1)), 18'($urandom), 18'($urandom));
      end else if (pick < 9) begin
        add_reading(18'($urandom), 1'($urandom_range(0, 1)), $urandom,
                    1'($urandom_range(0, 1)), 18'($urandom), 18'($urandom));
      end else begin
        pres = (thr_reg == 18'h3FFFF) ? 18'($urandom)
                                      : 18'($urandom_range(thr_reg + 1, 18'h3FFFF));
        if ($urandom_range(0, 99) < 30) begin
          if ($urandom_range(0, 9) == 0) clock_ms = clock_ms + $urandom_range(0, 5000);
          else clock_ms = clock_ms + $urandom_range(236, 2999);
          add_reading(pres, 1'b1, clock_ms, $urandom_range(0, 9) != 0,
                      red_dc + 18'($urandom_range(0, 4000)),
                      ir_dc + 18'($urandom_range(0, 4000)));
        end else begin
          add_reading(pres, 1'b0, $urandom, $urandom_range(0, 9) != 0,
                      red_dc + 18'($urandom_range(0, 4000)),
                      ir_dc + 18'($urandom_range(0, 4000)));
        end
      end
    end
  endtask

  task automatic drain();
    forever begin
      @(posedge clk);
      if (pending.size() == 0 && !in_valid && expected_reports.size() == 0) break;
    end
  endtask

  initial begin
    clear_track();
    spo2_est = FLOOR_RST;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Directed: presence edges, beat interval edges, time wrap, zero and
    // full-scale samples (zero mean saturates the ratio), window of one.
    add_reading(18'd0, 1'b1, 32'd500, 1'b1, 18'h3FFFF, 18'h3FFFF);
    add_reading(18'd7000, 1'b1, 32'd500, 1'b1, 18'd5, 18'd5);
    add_reading(18'd7001, 1'b1, 32'd1000, 1'b1, 18'd0, 18'd0);
    add_reading(18'h3FFFF, 1'b1, 32'd1000, 1'b1, 18'd0, 18'h3FFFF);
    add_reading(18'h3FFFF, 1'b1, 32'd1235, 1'b1, 18'h3FFFF, 18'd0);
    add_reading(18'h3FFFF, 1'b1, 32'd1471, 1'b0, 18'd1, 18'd1);
    add_reading(18'h3FFFF, 1'b1, 32'd4470, 1'b1, 18'h3FFFF, 18'h3FFFF);
    add_reading(18'h3FFFF, 1'b1, 32'd7470, 1'b1, 18'd100, 18'd90000);
    add_reading(18'h3FFFF, 1'b1, 32'hFFFF_FF00, 1'b1, 18'd90000, 18'd100);
    add_reading(18'h3FFFF, 1'b1, 32'd700, 1'b1, 18'h2AAAA, 18'h15555);
    add_reading(18'h3FFFF, 1'b0, 32'hFFFF_FFFF, 1'b1, 18'h15555, 18'h2AAAA);
    for (int i = 0; i < 10; i++)
      add_reading(18'h20000, 1'b1, 32'd1400 + 32'(i) * 32'd600, 1'b1,
                  18'd50000 + 18'(i) * 18'd900, 18'd60000 - 18'(i) * 18'd700);
    drain();

    write_reg(CFG_WINDOW, 32'd1);
    add_reading(18'h3FFFF, 1'b0, 32'd0, 1'b1, 18'd0, 18'd0);
    add_reading(18'h3FFFF, 1'b0, 32'd0, 1'b1, 18'd20000, 18'd30000);
    add_session(130);
    drain();

    // Sender gaps; full level filter weight extremes and floor at zero.
    send_idle_pct = 67;
    write_reg(CFG_LEVEL_F, 32'd0);
    write_reg(CFG_ESTIMATE_F, 32'd65535);
    write_reg(CFG_FLOOR, 32'd0);
    write_reg(CFG_WINDOW, 32'd4);
    add_session(130);
    drain();

    // Receiver stalls plus one long hold-off that backs the block up.
    send_idle_pct = 0;
    recv_stall_pct = 67;
    write_reg(CFG_LEVEL_F, 32'd65535);
    write_reg(CFG_ESTIMATE_F, 32'd0);
    write_reg(CFG_FLOOR, 32'd1000);
    write_reg(CFG_THRESHOLD, 32'd0);
    hold_req <= 1'b1;
    add_session(130);
    drain();

    // Both sides idle now and then; window of zero and the largest window.
    send_idle_pct = 7;
    recv_stall_pct = 7;
    write_reg(CFG_FLOOR, 32'd850);
    write_reg(CFG_LEVEL_F, 32'd40000);
    write_reg(CFG_ESTIMATE_F, 32'd20000);
    write_reg(CFG_WINDOW, 32'd0);
    add_session(100);
    drain();
    write_reg(CFG_WINDOW, 32'd255);
    write_reg(CFG_THRESHOLD, 32'd100000);
    add_session(120);
    drain();

    // Window lowered below the running count, then defaults restored.
    send_idle_pct = 0;
    recv_stall_pct = 0;
    write_reg(CFG_WINDOW, 32'd3);
    add_session(110);
    drain();
    write_reg(CFG_THRESHOLD, 32'd7000);
    write_reg(CFG_WINDOW, 32'd30);
    write_reg(CFG_LEVEL_F, 32'd62259);
    write_reg(CFG_ESTIMATE_F, 32'd45875);
    write_reg(CFG_FLOOR, 32'd900);
    send_idle_pct = 67;
    recv_stall_pct = 67;
    add_session(150);
    drain();

    // Threshold at full scale: every reading counts as no finger.
    send_idle_pct = 0;
    recv_stall_pct = 0;
    write_reg(CFG_THRESHOLD, 32'h3FFFF);
    add_session(60);
    drain();
    write_reg(CFG_THRESHOLD, 32'd7000);
    write_reg(CFG_WINDOW, 32'd8);
    add_session(100);
    drain();

    repeat (500) @(posedge clk);
    if (mismatches == 0 && expected_reports.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
